[hw/rtl/stwbc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stwbc_pkg
// shared types and constants of the single-track write-back cache policy
// ----------------------------------------------------------------------------
package stwbc_pkg;

  // geometry
  localparam int unsigned CylinderCount = 80;
  localparam int unsigned TrackSectors  = 18;
  localparam int unsigned SectorBytes   = 512;

  // field widths
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CylInW  = 8;
  localparam int unsigned HeadW   = 2;
  localparam int unsigned SectorW = 5;
  localparam int unsigned ByteW   = 10;
  localparam int unsigned ActionW = 2;
  localparam int unsigned CylW    = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AddrW   = 15;

  // request codes
  typedef enum logic [ModeW-1:0] {
    MODE_READ     = 3'd0,
    MODE_WRITE    = 3'd1,
    MODE_FLUSH    = 3'd2,
    MODE_DISK_CHG = 3'd3,
    MODE_WB_DONE  = 3'd4,
    MODE_FET_DONE = 3'd5
  } mode_e;

  typedef enum logic [ActionW-1:0] {
    ACT_FINISHED  = 2'd0,
    ACT_WRITEBACK = 2'd1,
    ACT_FETCH     = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_XFER    = 2'd2,
    ST_BUSY    = 2'd3
  } status_e;

  // waiting phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE          = 4'b0001,
    PH_WB_THEN_FETCH = 4'b0010,
    PH_FETCH         = 4'b0100,
    PH_FLUSH         = 4'b1000
  } phase_e;

endpackage : stwbc_pkg
`default_nettype wire

[hw/rtl/single_track_writeback_cache.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// single_track_writeback_cache
// policy for a one-cylinder write-back track cache
// ----------------------------------------------------------------------------
// Each word on the input channel is one event: a read or write request, a
// flush, a disk change, or a completion (writeback done, fetch done) from the
// track transfer engine. Each accepted word yields exactly one result word.
// A word is taken into an input register, decoded against the cache state
// (valid, dirty, cached cylinder, waiting phase, held request) and the result
// is written to the output register once that register is free, and a new
// word is accepted every cycle while the output is not stalled. The single
// decode stage sits between the two registers; the output register parts
// the two sides, and the input register is freed whenever the output
// register is empty or being taken. A miss on a dirty cache answers with a
// writeback request for the cached cylinder; the fetch of the requested
// cylinder follows when the writeback completes. A hit returns the byte
// address in the track buffer and marks a write dirty.
// ----------------------------------------------------------------------------
module single_track_writeback_cache (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request side
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [stwbc_pkg::ModeW-1:0]   mode_i,
  input  wire logic [stwbc_pkg::CylInW-1:0]  cylinder_i,
  input  wire logic [stwbc_pkg::HeadW-1:0]   head_i,
  input  wire logic [stwbc_pkg::SectorW-1:0] sector_i,
  input  wire logic [stwbc_pkg::ByteW-1:0]   byte_offset_i,
  input  wire logic [stwbc_pkg::ByteW-1:0]   byte_count_i,
  input  wire logic                          transfer_ok_i,
  // result side
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [stwbc_pkg::ActionW-1:0]      action_o,
  output logic [stwbc_pkg::CylW-1:0]         action_cylinder_o,
  output logic [stwbc_pkg::StatusW-1:0]      status_o,
  output logic [stwbc_pkg::AddrW-1:0]        buffer_address_o,
  output logic                               grant_write_o
);
  import stwbc_pkg::*;

  // ---------------- input register ----------------
  logic               s1_valid_q;
  logic [ModeW-1:0]   mode_q;
  logic [CylInW-1:0]  cyl_q;
  logic [HeadW-1:0]   head_q;
  logic [SectorW-1:0] sec_q;
  logic [ByteW-1:0]   off_q;
  logic [ByteW-1:0]   cnt_q;
  logic               ok_q;

  logic s1_adv;   // input register moves into the output register
  logic out_free; // output register can take a word this cycle

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q  <= mode_i;
      cyl_q   <= cylinder_i;
      head_q  <= head_i;
      sec_q   <= sector_i;
      off_q   <= byte_offset_i;
      cnt_q   <= byte_count_i;
      ok_q    <= transfer_ok_i;
    end
  end

  // ---------------- cache state ----------------
  logic           cache_valid_q, cache_valid_d;
  logic           track_dirty_q, track_dirty_d;
  logic [CylW-1:0] cached_cyl_q, cached_cyl_d;
  phase_e         phase_q, phase_d;
  // held request, written before it is ever read
  logic            held_wr_q, held_wr_d;
  logic [CylW-1:0] held_cyl_q, held_cyl_d;
  logic [AddrW-1:0] held_addr_q, held_addr_d;

  // ---------------- decode ----------------
  logic             bad_bounds;
  logic [ByteW:0]   span_end;
  logic [5:0]       track_slot;  // sector*2 + head
  logic [AddrW:0]   addr_wide;
  logic [AddrW-1:0] req_addr;
  logic             is_wr;
  logic             hit;

  assign span_end   = {1'b0, off_q} + {1'b0, cnt_q};
  assign bad_bounds = (cyl_q >= CylInW'(CylinderCount)) || (head_q > HeadW'(1))
                   || (sec_q >= SectorW'(TrackSectors))
                   || (off_q > ByteW'(SectorBytes)) || (cnt_q > ByteW'(SectorBytes))
                   || (span_end > (ByteW+1)'(SectorBytes));

  // buffer address: slot times the sector size plus the offset, kept to 15 bits
  assign track_slot = {sec_q, 1'b0} + 6'(head_q);
  assign addr_wide  = (AddrW+1)'(track_slot) * (AddrW+1)'(SectorBytes)
                    + (AddrW+1)'(off_q);
  assign req_addr   = addr_wide[AddrW-1:0];
  assign is_wr      = (mode_q == MODE_WRITE);
  assign hit        = cache_valid_q && (8'(cached_cyl_q) == cyl_q);

  // result of this word
  action_e          res_act;
  logic [CylW-1:0]  res_cyl;
  status_e          res_st;
  logic [AddrW-1:0] res_addr;
  logic             res_wr;

  always_comb begin
    cache_valid_d = cache_valid_q;
    track_dirty_d = track_dirty_q;
    cached_cyl_d  = cached_cyl_q;
    phase_d       = phase_q;
    held_wr_d     = held_wr_q;
    held_cyl_d    = held_cyl_q;
    held_addr_d   = held_addr_q;
    res_act       = ACT_FINISHED;
    res_cyl       = '0;
    res_st        = ST_OK;
    res_addr      = '0;
    res_wr        = 1'b0;

    case (mode_q)
      MODE_READ, MODE_WRITE: begin
        if (phase_q != PH_IDLE) begin
          res_st = ST_BUSY;
        end else if (bad_bounds) begin
          res_st = ST_INVALID;
        end else if (hit) begin
          // hit: grant at once, a write dirties the track
          if (is_wr) begin
            track_dirty_d = 1'b1;
          end
          res_addr = req_addr;
          res_wr   = is_wr;
        end else begin
          // miss: hold the request until the track is in
          held_wr_d   = is_wr;
          held_cyl_d  = cyl_q[CylW-1:0];
          held_addr_d = req_addr;
          if (cache_valid_q && track_dirty_q) begin
            phase_d = PH_WB_THEN_FETCH;
            res_act = ACT_WRITEBACK;
            res_cyl = cached_cyl_q;
          end else begin
            cache_valid_d = 1'b0;
            phase_d       = PH_FETCH;
            res_act       = ACT_FETCH;
            res_cyl       = cyl_q[CylW-1:0];
          end
        end
      end
      MODE_FLUSH: begin
        if (phase_q != PH_IDLE) begin
          res_st = ST_BUSY;
        end else if (cache_valid_q && track_dirty_q) begin
          phase_d = PH_FLUSH;
          res_act = ACT_WRITEBACK;
          res_cyl = cached_cyl_q;
        end
      end
      MODE_DISK_CHG: begin
        cache_valid_d = 1'b0;
      end
      MODE_WB_DONE: begin
        if (phase_q == PH_WB_THEN_FETCH) begin
          if (!ok_q) begin
            phase_d = PH_IDLE;
            res_st  = ST_XFER;
          end else begin
            track_dirty_d = 1'b0;
            cache_valid_d = 1'b0;
            phase_d       = PH_FETCH;
            res_act       = ACT_FETCH;
            res_cyl       = held_cyl_q;
          end
        end else if (phase_q == PH_FLUSH) begin
          phase_d = PH_IDLE;
          if (ok_q) begin
            track_dirty_d = 1'b0;
          end else begin
            res_st = ST_XFER;
          end
        end else begin
          res_st = ST_BUSY;
        end
      end
      MODE_FET_DONE: begin
        if (phase_q == PH_FETCH) begin
          phase_d = PH_IDLE;
          if (!ok_q) begin
            cache_valid_d = 1'b0;
            res_st        = ST_XFER;
          end else begin
            // track is in: resume the held request
            cache_valid_d = 1'b1;
            cached_cyl_d  = held_cyl_q;
            track_dirty_d = held_wr_q;
            res_addr      = held_addr_q;
            res_wr        = held_wr_q;
          end
        end else begin
          res_st = ST_BUSY;
        end
      end
      default: begin
        // unused request codes
        res_st = ST_BUSY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_valid_q <= 1'b0;
      track_dirty_q <= 1'b0;
      cached_cyl_q  <= '0;
      phase_q       <= PH_IDLE;
    end else if (s1_adv) begin
      cache_valid_q <= cache_valid_d;
      track_dirty_q <= track_dirty_d;
      cached_cyl_q  <= cached_cyl_d;
      phase_q       <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      held_wr_q   <= held_wr_d;
      held_cyl_q  <= held_cyl_d;
      held_addr_q <= held_addr_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      action_o          <= res_act;
      action_cylinder_o <= res_cyl;
      status_o          <= res_st;
      buffer_address_o  <= res_addr;
      grant_write_o     <= res_wr;
    end
  end

  // ---------------- assertions ----------------
  a_request_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o != ACT_FINISHED) |-> (status_o == ST_OK))
    else $error("transfer request carries a non-success status");

  a_grant_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && grant_write_o |-> (action_o == ACT_FINISHED) && (status_o == ST_OK))
    else $error("write grant on a failed or pending word");

  a_phase_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("waiting phase lost its one-hot code");

  a_fetch_invalid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FETCH) |-> !cache_valid_q)
    else $error("cache marked valid while a fetch is pending");

  a_hold_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_o && !out_ready_i |=> s1_valid_q)
    else $error("staged word dropped during an output stall");

endmodule : single_track_writeback_cache
`default_nettype wire
